// File: rtl/core/pcc_pkg.sv
// Package for the polyline corner chamfer block: widths, coordinate type,
// sequencer states and a few arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int COORD_BITS = 31;
  localparam int FRAC_BITS  = 16;
  localparam int MIN_W      = 24;

  // a coordinate difference, its square and the Q.F root of a sum of squares
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ROOT_W = 48;
  localparam int PROD_W = DIFF_W + FRAC_BITS;
  localparam int FIX_W  = PROD_W + 2;
  localparam int THR_W  = 2 * MIN_W - 2;

  localparam int MUL_CNT_W = $clog2(DIFF_W);
  localparam int SQ_CNT_W  = $clog2(ROOT_W);
  localparam int DIV_CNT_W = $clog2(ROOT_W + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MIN_W-1:0]             minlen_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CR1,
    ST_CR2,
    ST_L1A,
    ST_L1B,
    ST_L1R,
    ST_L2A,
    ST_L2B,
    ST_L2R,
    ST_CD1,
    ST_CD2,
    ST_RT1,
    ST_RT2,
    ST_PSX,
    ST_PSY,
    ST_PEX,
    ST_PEY,
    ST_OFT,
    ST_OFX,
    ST_OFY,
    ST_OFE,
    ST_FIN
  } state_e;

  // which point the spacing filter is looking at
  typedef enum logic [1:0] {
    CTX_KEEP,
    CTX_START,
    CTX_END
  } ctx_e;

  // magnitude of a difference
  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  // h*2^F -/+ p, then divided by 2^F with truncation toward zero
  function automatic coord_t trunc_q(input coord_t h, input logic [PROD_W-1:0] p,
                                     input logic sub);
    logic signed [FIX_W-1:0] hv;
    logic signed [FIX_W-1:0] v;
    logic [FIX_W-1:0]        m;
    hv = {{(FIX_W-COORD_BITS-FRAC_BITS){h[COORD_BITS-1]}}, h, {FRAC_BITS{1'b0}}};
    v  = sub ? hv - $signed({2'b00, p}) : hv + $signed({2'b00, p});
    if (v[FIX_W-1]) begin
      m = FIX_W'(-v) >> FRAC_BITS;
      v = -$signed(m);
    end else begin
      v = v >>> FRAC_BITS;
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/pcc_in_if.sv
// Input channel of the corner chamfer block: one polyline point per beat.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

interface pcc_in_if;
  logic             valid;
  logic             ready;
  pcc_pkg::coord_t  point_x;
  pcc_pkg::coord_t  point_y;
  logic             final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

// File: rtl/core/pcc_out_if.sv
// Output channel of the corner chamfer block: one emitted point per beat.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

interface pcc_out_if;
  logic             valid;
  logic             ready;
  pcc_pkg::coord_t  out_x;
  pcc_pkg::coord_t  out_y;
  logic             out_final;

  modport source (output valid, out_x, out_y, out_final, input ready);
  modport sink   (input valid, out_x, out_y, out_final, output ready);
endinterface

// File: rtl/core/polyline_corner_chamfer.sv
// Polyline corner chamfer: collinear drop, 45-degree chamfer, spacing filter.
// Depends on pcc_pkg, pcc_in_if and pcc_out_if.
`timescale 1ns / 1ps

//  channel   dir  beat contents
//  pt_i      in   point_x, point_y, final_point
//  pt_o      out  out_x, out_y, out_final
//  cfg       in   cfg_we_i / cfg_wdata_i : min_segment_length
//
// One point at a time. The work is done by one 1-bit-per-cycle shift-add
// multiplier, a radix-2 root unit (48 steps) and a radix-2 divider (16 or
// 49 steps), used one after another. Reset is asynchronous and needs no
// clearing pass. A stalled output holds the sequencer only when it has a
// point to emit; a single output register parts the sides.

module polyline_corner_chamfer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  pcc_pkg::minlen_t cfg_wdata_i,
  pcc_in_if.sink           pt_i,
  pcc_out_if.source        pt_o
);
  import pcc_pkg::*;

  // ---------------------------------------------------------------- state
  state_e  st_q, st_d;
  ctx_e    ctx_q, ctx_d;
  logic [1:0] phase_q, phase_d;
  minlen_t msl_q;

  coord_t in_x_q, in_y_q, in_x_d, in_y_d;
  logic   in_f_q, in_f_d;
  coord_t held_x_q, held_y_q, held_x_d, held_y_d;
  coord_t anc_x_q, anc_y_q, anc_x_d, anc_y_d;
  coord_t kept_x_q, kept_y_q, kept_x_d, kept_y_d;
  coord_t sx_q, sy_q, ex_q, ey_q, sx_d, sy_d, ex_d, ey_d;

  logic signed [SQ_W:0] p1_q, p1_d, p2;
  logic [SQ_W-1:0]      acc_q, acc_d, dsq;
  logic [ROOT_W-1:0]    len1_q, len2_q, len1_d, len2_d, cd_q, cd_d, cmin;
  logic [FRAC_BITS-1:0] r1_q, r2_q, r1_d, r2_d;
  logic [THR_W-1:0]     thr_q, thr_d;
  logic                 pass_q, pass_d;

  // output register
  logic   ov_q, ov_d, out_load, slot_free;
  coord_t ox_q, oy_q, ld_x, ld_y;
  logic   of_q, ld_f;

  // ------------------------------------------------------ corner geometry
  logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2, ddx, ddy;
  logic [DIFF_W-1:0]        mdx1, mdy1, mdx2, mdy2;
  logic                     horiz, vert;
  coord_t                   of_x, of_y;

  assign dx1  = DIFF_W'(held_x_q) - DIFF_W'(anc_x_q);
  assign dy1  = DIFF_W'(held_y_q) - DIFF_W'(anc_y_q);
  assign dx2  = DIFF_W'(in_x_q) - DIFF_W'(held_x_q);
  assign dy2  = DIFF_W'(in_y_q) - DIFF_W'(held_y_q);
  assign mdx1 = mag(dx1);
  assign mdy1 = mag(dy1);
  assign mdx2 = mag(dx2);
  assign mdy2 = mag(dy2);
  assign horiz = mdx1 > mdy1;
  assign vert  = mdy2 > mdx2;

  // point under the spacing filter
  always_comb begin
    case (ctx_q)
      CTX_START: begin
        of_x = sx_q;
        of_y = sy_q;
      end
      CTX_END: begin
        of_x = ex_q;
        of_y = ey_q;
      end
      default: begin
        of_x = held_x_q;
        of_y = held_y_q;
      end
    endcase
  end
  assign ddx = DIFF_W'(of_x) - DIFF_W'(kept_x_q);
  assign ddy = DIFF_W'(of_y) - DIFF_W'(kept_y_q);

  // ----------------------------------------------- shift-add multiplier
  logic                 mul_go, mul_run_q, mul_done_q;
  logic [DIFF_W-1:0]    mul_ina, mul_inb, mul_b_q;
  logic [SQ_W-1:0]      mul_a_q, mul_p_q;
  logic [MUL_CNT_W-1:0] mul_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_run_q  <= 1'b0;
      mul_done_q <= 1'b0;
    end else begin
      mul_done_q <= mul_run_q && (mul_cnt_q == MUL_CNT_W'(DIFF_W - 1));
      if (mul_go) begin
        mul_run_q <= 1'b1;
      end else if (mul_cnt_q == MUL_CNT_W'(DIFF_W - 1)) begin
        mul_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      mul_a_q   <= SQ_W'(mul_ina);
      mul_b_q   <= mul_inb;
      mul_p_q   <= '0;
      mul_cnt_q <= '0;
    end else if (mul_run_q) begin
      if (mul_b_q[0]) begin
        mul_p_q <= mul_p_q + mul_a_q;
      end
      mul_a_q   <= mul_a_q << 1;
      mul_b_q   <= mul_b_q >> 1;
      mul_cnt_q <= mul_cnt_q + 1'b1;
    end
  end

  // ------------------------------------------------ radix-2 square root
  logic                sq_go, sq_run_q, sq_done_q;
  logic [SQ_W-1:0]     sq_in, sq_q;
  logic [ROOT_W+1:0]   sq_rem_q;
  logic [ROOT_W-1:0]   sq_root_q;
  logic [SQ_CNT_W-1:0] sq_cnt_q;
  logic [ROOT_W+3:0]   sq_r2;
  logic [ROOT_W+1:0]   sq_trial;
  logic                sq_ge;

  assign sq_r2    = {sq_rem_q, sq_q[SQ_W-1 -: 2]};
  assign sq_trial = {sq_root_q, 2'b01};
  assign sq_ge    = sq_r2 >= (ROOT_W+4)'(sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_run_q  <= 1'b0;
      sq_done_q <= 1'b0;
    end else begin
      sq_done_q <= sq_run_q && (sq_cnt_q == SQ_CNT_W'(ROOT_W - 1));
      if (sq_go) begin
        sq_run_q <= 1'b1;
      end else if (sq_cnt_q == SQ_CNT_W'(ROOT_W - 1)) begin
        sq_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_go) begin
      sq_q      <= sq_in;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= '0;
    end else if (sq_run_q) begin
      sq_q      <= sq_q << 2;
      sq_rem_q  <= sq_ge ? (ROOT_W+2)'(sq_r2 - (ROOT_W+4)'(sq_trial))
                         : (ROOT_W+2)'(sq_r2);
      sq_root_q <= {sq_root_q[ROOT_W-2:0], sq_ge};
      sq_cnt_q  <= sq_cnt_q + 1'b1;
    end
  end

  // ------------------------------------------------- restoring divider
  logic                 dv_go, dv_run_q, dv_done_q, dv_zero_q;
  logic [ROOT_W-1:0]    dv_num, dv_den, dv_den_q, dv_rem_q;
  logic [ROOT_W:0]      dv_dvd, dv_dvd_q, dv_quo_q, dv_t, dv_res;
  logic [DIV_CNT_W-1:0] dv_iters, dv_last_q, dv_cnt_q;
  logic                 dv_ge;

  assign dv_t   = {dv_rem_q, dv_dvd_q[ROOT_W]};
  assign dv_ge  = dv_t >= {1'b0, dv_den_q};
  assign dv_res = dv_zero_q ? '0 : dv_quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_run_q  <= 1'b0;
      dv_done_q <= 1'b0;
    end else begin
      dv_done_q <= dv_run_q && (dv_cnt_q == dv_last_q);
      if (dv_go) begin
        dv_run_q <= 1'b1;
      end else if (dv_cnt_q == dv_last_q) begin
        dv_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_go) begin
      dv_rem_q  <= dv_num;
      dv_dvd_q  <= dv_dvd;
      dv_den_q  <= dv_den;
      dv_quo_q  <= '0;
      dv_cnt_q  <= '0;
      dv_last_q <= dv_iters - 1'b1;
      dv_zero_q <= (dv_den == '0) || (dv_num >= dv_den);
    end else if (dv_run_q) begin
      dv_rem_q <= dv_ge ? ROOT_W'(dv_t - {1'b0, dv_den_q}) : ROOT_W'(dv_t);
      dv_dvd_q <= dv_dvd_q << 1;
      dv_quo_q <= {dv_quo_q[ROOT_W-1:0], dv_ge};
      dv_cnt_q <= dv_cnt_q + 1'b1;
    end
  end

  // ------------------------------------------------------------ sequencer
  assign slot_free = !ov_q || pt_o.ready;
  assign pt_i.ready = (st_q == ST_IDLE);
  assign p2  = (dy1[DIFF_W-1] ^ dx2[DIFF_W-1]) ? -$signed({1'b0, mul_p_q})
                                               : $signed({1'b0, mul_p_q});
  assign dsq = acc_q + mul_p_q;

  always_comb begin
    cmin = dv_res[ROOT_W-1:0];
    if (cd_q < cmin) cmin = cd_q;
    if (ROOT_W'({msl_q, {FRAC_BITS{1'b0}}}) < cmin) cmin = ROOT_W'({msl_q, {FRAC_BITS{1'b0}}});
  end

  always_comb begin
    st_d     = st_q;
    ctx_d    = ctx_q;
    phase_d  = phase_q;
    in_x_d   = in_x_q;
    in_y_d   = in_y_q;
    in_f_d   = in_f_q;
    held_x_d = held_x_q;
    held_y_d = held_y_q;
    anc_x_d  = anc_x_q;
    anc_y_d  = anc_y_q;
    kept_x_d = kept_x_q;
    kept_y_d = kept_y_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    ex_d     = ex_q;
    ey_d     = ey_q;
    p1_d     = p1_q;
    acc_d    = acc_q;
    len1_d   = len1_q;
    len2_d   = len2_q;
    cd_d     = cd_q;
    r1_d     = r1_q;
    r2_d     = r2_q;
    thr_d    = thr_q;
    pass_d   = pass_q;
    out_load = 1'b0;
    ld_x     = in_x_q;
    ld_y     = in_y_q;
    ld_f     = in_f_q;
    mul_go   = 1'b0;
    mul_ina  = '0;
    mul_inb  = '0;
    sq_go    = 1'b0;
    sq_in    = '0;
    dv_go    = 1'b0;
    dv_num   = '0;
    dv_dvd   = '0;
    dv_den   = '0;
    dv_iters = '0;

    case (st_q)
      ST_IDLE: begin
        if (pt_i.valid) begin
          in_x_d = pt_i.point_x;
          in_y_d = pt_i.point_y;
          in_f_d = pt_i.final_point;
          st_d   = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (phase_q)
          2'd1: begin
            if (!in_f_q) begin
              held_x_d = in_x_q;
              held_y_d = in_y_q;
              phase_d  = 2'd2;
              st_d     = ST_IDLE;
            end else if (slot_free) begin
              out_load = 1'b1;
              phase_d  = 2'd0;
              st_d     = ST_IDLE;
            end
          end
          2'd2: begin
            mul_go  = 1'b1;
            mul_ina = mdx1;
            mul_inb = mdy2;
            st_d    = ST_CR1;
          end
          default: begin
            // first point of a polyline goes straight out
            if (slot_free) begin
              out_load = 1'b1;
              anc_x_d  = in_x_q;
              anc_y_d  = in_y_q;
              kept_x_d = in_x_q;
              kept_y_d = in_y_q;
              phase_d  = in_f_q ? 2'd0 : 2'd1;
              st_d     = ST_IDLE;
            end
          end
        endcase
      end

      // cross products for the collinear test
      ST_CR1: begin
        if (mul_done_q) begin
          p1_d = (dx1[DIFF_W-1] ^ dy2[DIFF_W-1]) ? -$signed({1'b0, mul_p_q})
                                                 : $signed({1'b0, mul_p_q});
          mul_go  = 1'b1;
          mul_ina = mdy1;
          mul_inb = mdx2;
          st_d    = ST_CR2;
        end
      end

      ST_CR2: begin
        if (mul_done_q) begin
          if (p1_q == p2) begin
            st_d = ST_FIN;
          end else if (horiz == vert) begin
            mul_go  = 1'b1;
            mul_ina = mdx1;
            mul_inb = mdx1;
            st_d    = ST_L1A;
          end else begin
            ctx_d   = CTX_KEEP;
            mul_go  = 1'b1;
            mul_ina = DIFF_W'(msl_q);
            mul_inb = DIFF_W'(msl_q);
            st_d    = ST_OFT;
          end
        end
      end

      // leg lengths in Q.F
      ST_L1A: begin
        if (mul_done_q) begin
          acc_d   = mul_p_q;
          mul_go  = 1'b1;
          mul_ina = mdy1;
          mul_inb = mdy1;
          st_d    = ST_L1B;
        end
      end

      ST_L1B: begin
        if (mul_done_q) begin
          sq_go = 1'b1;
          sq_in = dsq;
          st_d  = ST_L1R;
        end
      end

      ST_L1R: begin
        if (sq_done_q) begin
          len1_d  = sq_root_q;
          mul_go  = 1'b1;
          mul_ina = mdx2;
          mul_inb = mdx2;
          st_d    = ST_L2A;
        end
      end

      ST_L2A: begin
        if (mul_done_q) begin
          acc_d   = mul_p_q;
          mul_go  = 1'b1;
          mul_ina = mdy2;
          mul_inb = mdy2;
          st_d    = ST_L2B;
        end
      end

      ST_L2B: begin
        if (mul_done_q) begin
          sq_go = 1'b1;
          sq_in = dsq;
          st_d  = ST_L2R;
        end
      end

      ST_L2R: begin
        if (sq_done_q) begin
          len2_d   = sq_root_q;
          dv_go    = 1'b1;
          dv_dvd   = {len1_q, 1'b0};
          dv_den   = ROOT_W'(5);
          dv_iters = DIV_CNT_W'(ROOT_W + 1);
          st_d     = ST_CD1;
        end
      end

      // chamfer distance: 0.4 of the shorter leg, capped by min length
      ST_CD1: begin
        if (dv_done_q) begin
          cd_d     = dv_res[ROOT_W-1:0];
          dv_go    = 1'b1;
          dv_dvd   = {len2_q, 1'b0};
          dv_den   = ROOT_W'(5);
          dv_iters = DIV_CNT_W'(ROOT_W + 1);
          st_d     = ST_CD2;
        end
      end

      ST_CD2: begin
        if (dv_done_q) begin
          cd_d = cmin;
          if (cmin >= ROOT_W'({msl_q[MIN_W-1:1], {FRAC_BITS{1'b0}}})) begin
            dv_go    = 1'b1;
            dv_num   = cmin;
            dv_den   = len1_q;
            dv_iters = DIV_CNT_W'(FRAC_BITS);
            st_d     = ST_RT1;
          end else begin
            ctx_d   = CTX_KEEP;
            mul_go  = 1'b1;
            mul_ina = DIFF_W'(msl_q);
            mul_inb = DIFF_W'(msl_q);
            st_d    = ST_OFT;
          end
        end
      end

      // leg ratios
      ST_RT1: begin
        if (dv_done_q) begin
          r1_d     = dv_res[FRAC_BITS-1:0];
          dv_go    = 1'b1;
          dv_num   = cd_q;
          dv_den   = len2_q;
          dv_iters = DIV_CNT_W'(FRAC_BITS);
          st_d     = ST_RT2;
        end
      end

      ST_RT2: begin
        if (dv_done_q) begin
          r2_d    = dv_res[FRAC_BITS-1:0];
          mul_go  = 1'b1;
          mul_ina = mdx1;
          mul_inb = DIFF_W'(r1_q);
          st_d    = ST_PSX;
        end
      end

      // chamfer points
      ST_PSX: begin
        if (mul_done_q) begin
          sx_d    = trunc_q(held_x_q, mul_p_q[PROD_W-1:0], !dx1[DIFF_W-1]);
          mul_go  = 1'b1;
          mul_ina = mdy1;
          mul_inb = DIFF_W'(r1_q);
          st_d    = ST_PSY;
        end
      end

      ST_PSY: begin
        if (mul_done_q) begin
          sy_d    = trunc_q(held_y_q, mul_p_q[PROD_W-1:0], !dy1[DIFF_W-1]);
          mul_go  = 1'b1;
          mul_ina = mdx2;
          mul_inb = DIFF_W'(r2_q);
          st_d    = ST_PEX;
        end
      end

      ST_PEX: begin
        if (mul_done_q) begin
          ex_d    = trunc_q(held_x_q, mul_p_q[PROD_W-1:0], dx2[DIFF_W-1]);
          mul_go  = 1'b1;
          mul_ina = mdy2;
          mul_inb = DIFF_W'(r2_q);
          st_d    = ST_PEY;
        end
      end

      ST_PEY: begin
        if (mul_done_q) begin
          ey_d    = trunc_q(held_y_q, mul_p_q[PROD_W-1:0], dy2[DIFF_W-1]);
          ctx_d   = CTX_START;
          mul_go  = 1'b1;
          mul_ina = DIFF_W'(msl_q);
          mul_inb = DIFF_W'(msl_q);
          st_d    = ST_OFT;
        end
      end

      // spacing filter
      ST_OFT: begin
        if (mul_done_q) begin
          thr_d   = mul_p_q[2*MIN_W-1:2];
          mul_go  = 1'b1;
          mul_ina = mag(ddx);
          mul_inb = mag(ddx);
          st_d    = ST_OFX;
        end
      end

      ST_OFX: begin
        if (mul_done_q) begin
          acc_d   = mul_p_q;
          mul_go  = 1'b1;
          mul_ina = mag(ddy);
          mul_inb = mag(ddy);
          st_d    = ST_OFY;
        end
      end

      ST_OFY: begin
        if (mul_done_q) begin
          pass_d = dsq >= SQ_W'(thr_q);
          st_d   = ST_OFE;
        end
      end

      ST_OFE: begin
        if (!pass_q || slot_free) begin
          if (pass_q) begin
            out_load = 1'b1;
            ld_x     = of_x;
            ld_y     = of_y;
            ld_f     = 1'b0;
            kept_x_d = of_x;
            kept_y_d = of_y;
          end
          case (ctx_q)
            CTX_START: begin
              ctx_d   = CTX_END;
              mul_go  = 1'b1;
              mul_ina = DIFF_W'(msl_q);
              mul_inb = DIFF_W'(msl_q);
              st_d    = ST_OFT;
            end
            CTX_END: begin
              anc_x_d = ex_q;
              anc_y_d = ey_q;
              st_d    = ST_FIN;
            end
            default: begin
              anc_x_d = held_x_q;
              anc_y_d = held_y_q;
              st_d    = ST_FIN;
            end
          endcase
        end
      end

      // the new point is held, or closes the polyline
      ST_FIN: begin
        if (!in_f_q) begin
          held_x_d = in_x_q;
          held_y_d = in_y_q;
          st_d     = ST_IDLE;
        end else if (slot_free) begin
          out_load = 1'b1;
          ld_f     = 1'b1;
          kept_x_d = in_x_q;
          kept_y_d = in_y_q;
          phase_d  = 2'd0;
          st_d     = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ctx_q    <= CTX_KEEP;
      phase_q  <= 2'd0;
      msl_q    <= MIN_W'(200000);
      ov_q     <= 1'b0;
      held_x_q <= '0;
      held_y_q <= '0;
      anc_x_q  <= '0;
      anc_y_q  <= '0;
      kept_x_q <= '0;
      kept_y_q <= '0;
    end else begin
      st_q     <= st_d;
      ctx_q    <= ctx_d;
      phase_q  <= phase_d;
      ov_q     <= ov_d;
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
      anc_x_q  <= anc_x_d;
      anc_y_q  <= anc_y_d;
      kept_x_q <= kept_x_d;
      kept_y_q <= kept_y_d;
      if (cfg_we_i) begin
        msl_q <= cfg_wdata_i;
      end
    end
  end

  assign ov_d = out_load ? 1'b1 : (pt_o.ready ? 1'b0 : ov_q);

  // working payload
  always_ff @(posedge clk_i) begin
    in_x_q <= in_x_d;
    in_y_q <= in_y_d;
    in_f_q <= in_f_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    p1_q   <= p1_d;
    acc_q  <= acc_d;
    len1_q <= len1_d;
    len2_q <= len2_d;
    cd_q   <= cd_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    thr_q  <= thr_d;
    pass_q <= pass_d;
    if (out_load) begin
      ox_q <= ld_x;
      oy_q <= ld_y;
      of_q <= ld_f;
    end
  end

  assign pt_o.valid     = ov_q;
  assign pt_o.out_x     = ox_q;
  assign pt_o.out_y     = oy_q;
  assign pt_o.out_final = of_q;

endmodule

// File: verif/tb_top.sv
// Testbench for polyline_corner_chamfer: directed and random polylines, checked
// beat by beat against a behavioural predictor of the corner and spacing stages.
// Depends on pcc_pkg, pcc_in_if, pcc_out_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import pcc_pkg::*;

  localparam int  CLK_HALF   = 10;
  localparam int  FRAC       = 16;
  localparam int  DRAIN_CYC  = 1000;
  localparam longint LIMIT_CYC = 4000000;
  localparam int  RAND_ITEMS = 410;
  localparam int  CFG_IDX_MIN = 0;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   f;
  } pt_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  minlen_t cfg_wdata_i = '0;

  pcc_in_if  pt_in ();
  pcc_out_if pt_out ();

  polyline_corner_chamfer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pt_i        (pt_in.sink),
    .pt_o        (pt_out.source)
  );

  // clock
  always #CLK_HALF clk_i = ~clk_i;

  // predictor state
  logic [63:0] min_len;
  int unsigned phase_q;
  longint held_x, held_y, anchor_x, anchor_y, kept_x, kept_y;
  pt_beat_t   emitted_q[$];
  int         step_emits;
  int         errors = 0;
  longint     cyc = 0;
  int         hold_req = 0;

  function automatic logic [63:0] umag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] root_q(logic [63:0] sq);
    logic [63:0] root, rem, pair, trial;
    root = 0;
    rem = 0;
    for (int i = 31 + FRAC; i >= 0; i--) begin
      pair = (i >= FRAC) ? ((sq >> (2 * (i - FRAC))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, rem;
    q = 0;
    rem = num;
    if (den == 0 || num >= den) return 64'd0;
    for (int i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint drop_frac(longint v);
    if (v < 0) return -longint'(64'(-v) >> FRAC);
    return v >>> FRAC;
  endfunction

  function void push_point(longint x, longint y, logic f);
    pt_beat_t b;
    if (step_emits >= 3) return;
    b.x = coord_t'(x);
    b.y = coord_t'(y);
    b.f = f;
    emitted_q = {emitted_q, b};
    step_emits++;
  endfunction

  // spacing stage for a non-final point
  function void space_filter(longint x, longint y);
    logic [63:0] ax, ay, d2, thr;
    ax = umag(x - kept_x);
    ay = umag(y - kept_y);
    d2 = ax * ax + ay * ay;
    thr = (min_len * min_len) / 4;
    if (d2 >= thr) begin
      push_point(x, y, 1'b0);
      kept_x = x;
      kept_y = y;
    end
  endfunction

  // corner stage on the held point, given the next one
  function void corner_stage(longint nx, longint ny);
    longint dx1, dy1, dx2, dy2, r1, r2, sx, sy, ex, ey;
    logic [63:0] len1, len2, cd, c2, cm;
    logic horiz, vert;
    dx1 = held_x - anchor_x;
    dy1 = held_y - anchor_y;
    dx2 = nx - held_x;
    dy2 = ny - held_y;
    if (dx1 * dy2 == dy1 * dx2) return;
    horiz = umag(dx1) > umag(dy1);
    vert  = umag(dy2) > umag(dx2);
    if (horiz == vert) begin
      len1 = root_q(umag(dx1) * umag(dx1) + umag(dy1) * umag(dy1));
      len2 = root_q(umag(dx2) * umag(dx2) + umag(dy2) * umag(dy2));
      cd = (2 * len1) / 5;
      c2 = (2 * len2) / 5;
      cm = min_len << FRAC;
      if (c2 < cd) cd = c2;
      if (cm < cd) cd = cm;
      if (cd >= ((min_len >> 1) << FRAC)) begin
        r1 = longint'(frac_div(cd, len1));
        r2 = longint'(frac_div(cd, len2));
        sx = drop_frac(held_x * 65536 - dx1 * r1);
        sy = drop_frac(held_y * 65536 - dy1 * r1);
        ex = drop_frac(held_x * 65536 + dx2 * r2);
        ey = drop_frac(held_y * 65536 + dy2 * r2);
        space_filter(sx, sy);
        space_filter(ex, ey);
        anchor_x = ex;
        anchor_y = ey;
        return;
      end
    end
    space_filter(held_x, held_y);
    anchor_x = held_x;
    anchor_y = held_y;
  endfunction

  function void predict_point(coord_t px, coord_t py, logic fin);
    longint x, y;
    x = longint'(px);
    y = longint'(py);
    step_emits = 0;
    if (phase_q == 1) begin
      if (fin) begin
        push_point(x, y, 1'b1);
        phase_q = 0;
      end else begin
        held_x = x;
        held_y = y;
        phase_q = 2;
      end
    end else if (phase_q == 2) begin
      corner_stage(x, y);
      if (fin) begin
        push_point(x, y, 1'b1);
        kept_x = x;
        kept_y = y;
        phase_q = 0;
      end else begin
        held_x = x;
        held_y = y;
      end
    end else begin
      push_point(x, y, fin);
      anchor_x = x;
      kept_x = x;
      anchor_y = y;
      kept_y = y;
      phase_q = fin ? 0 : 1;
    end
  endfunction

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cyc);
    errors++;
  endtask

  // receiver: check each accepted beat, then pick the next ready level
  int rx_per = 1, rx_duty = 1, rx_phase = 0, hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pt_beat_t want;
    if (!rst_ni) begin
      pt_out.ready <= 1'b0;
    end else begin
      if (pt_out.valid && pt_out.ready) begin
        if (emitted_q.size() == 0) begin
          report_mismatch("unexpected beat x", 0, pt_out.out_x);
        end else begin
          want = emitted_q.pop_front();
          if (pt_out.out_x !== want.x) report_mismatch("out_x", want.x, pt_out.out_x);
          if (pt_out.out_y !== want.y) report_mismatch("out_y", want.y, pt_out.out_y);
          if (pt_out.out_final !== want.f)
            report_mismatch("out_final", want.f, pt_out.out_final);
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt_out.ready <= 1'b0;
      end else begin
        if (rx_phase == 0 && $urandom_range(0, 7) == 0) begin
          rx_per = $urandom_range(1, 9);
          rx_duty = ($urandom_range(0, 2) == 0) ? rx_per : $urandom_range(1, rx_per);
        end
        pt_out.ready <= (rx_phase < rx_duty);
        rx_phase = (rx_phase + 1) % rx_per;
      end
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;

  task automatic send_point(coord_t x, coord_t y, logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        pt_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pt_in.valid <= 1'b1;
    pt_in.point_x <= x;
    pt_in.point_y <= y;
    pt_in.final_point <= fin;
    do @(posedge clk_i); while (!pt_in.ready);
    predict_point(x, y, fin);
  endtask

  task automatic settle();
    pt_in.valid <= 1'b0;
    @(posedge clk_i);
    wait (emitted_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_min_len(minlen_t v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (CFG_IDX_MIN == 0) min_len = 64'(v);
  endtask

  // --- directed tests ---
  task automatic test_short_lines();
    send_point(31'sd5, -31'sd7, 1'b1);
    send_point(31'sd0, 31'sd0, 1'b0);
    send_point(31'sd1000000, 31'sd3, 1'b1);
  endtask

  task automatic test_corners();
    // right angle, chamfered
    send_point(31'sd0, 31'sd0, 1'b0);
    send_point(31'sd2000000, 31'sd0, 1'b0);
    send_point(31'sd2000000, 31'sd2000000, 1'b0);
    // collinear continuation
    send_point(31'sd2000000, 31'sd3000000, 1'b0);
    // shallow turn, kept
    send_point(31'sd2100000, 31'sd6000000, 1'b0);
    // short legs, chamfer too small
    send_point(31'sd2100100, 31'sd6000000, 1'b0);
    send_point(31'sd2100100, -31'sd100, 1'b1);
  endtask

  task automatic test_extremes();
    send_point(-31'sd1073741824, -31'sd1073741824, 1'b0);
    send_point(31'sd1073741823, -31'sd1073741824, 1'b0);
    send_point(31'sd1073741823, 31'sd1073741823, 1'b0);
    send_point(-31'sd1073741824, 31'sd1073741823, 1'b1);
  endtask

  task automatic test_zero_min();
    write_min_len(24'd0);
    send_point(31'sd10, 31'sd10, 1'b0);
    send_point(31'sd50, 31'sd10, 1'b0);
    send_point(31'sd50, 31'sd90, 1'b0);
    send_point(31'sd50, 31'sd90, 1'b1);
  endtask

  task automatic test_max_min();
    write_min_len(24'hFFFFFF);
    send_point(-31'sd500000000, 31'sd0, 1'b0);
    send_point(31'sd0, 31'sd0, 1'b0);
    send_point(31'sd0, 31'sd500000000, 1'b1);
  endtask

  // output held off while input keeps coming
  task automatic test_backpressure();
    write_min_len(24'd1000);
    hold_req = 3000;
    for (int i = 0; i < 8; i++)
      send_point(coord_t'(i * 5000), coord_t'((i % 2) * 5000), i == 7);
  endtask

  // --- random polylines ---
  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  task automatic test_random();
    int sent = 0, since_cfg = 0, n;
    longint x, y, dx, dy, span;
    logic [23:0] m;
    while (sent < RAND_ITEMS) begin
      if (since_cfg > 90) begin
        case ($urandom_range(0, 5))
          0: m = 24'd0;
          1: m = 24'hFFFFFF;
          2: m = 24'd1;
          3: m = 24'd200000;
          default: m = 24'($urandom_range(2, 50000));
        endcase
        write_min_len(m);
        since_cfg = 0;
      end
      n = $urandom_range(1, 9);
      span = longint'(min_len) * 4 + 16;
      x = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
      y = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
        end else begin
          send_point(coord_t'(x), coord_t'(y), k == n - 1);
        end
        case ($urandom_range(0, 5))
          0, 1: begin dx = $urandom_range(0, span); dy = $urandom_range(0, span / 8); end
          2, 3: begin dy = $urandom_range(0, span); dx = $urandom_range(0, span / 8); end
          4: begin dx = $urandom_range(0, span); dy = dx; end
          default: begin dx = $urandom_range(0, 64); dy = $urandom_range(0, 64); end
        endcase
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        x = x + dx;
        y = y + dy;
        sent++;
        since_cfg++;
      end
    end
  endtask

  initial begin
    min_len = 64'd200000;
    phase_q = 0;
    held_x = 0; held_y = 0; anchor_x = 0; anchor_y = 0; kept_x = 0; kept_y = 0;
    pt_in.valid = 1'b0;
    pt_in.point_x = '0;
    pt_in.point_y = '0;
    pt_in.final_point = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_lines();
    test_corners();
    test_extremes();
    test_zero_min();
    test_max_min();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
